@@ hw/rtl/mtc_pkg.sv @@
// Package for the Morse timing classifier: widths, reset values, symbol codes,
// register indexes and the controller state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtc_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int DOT_WIDTH           = 16;
   localparam int NOM_WIDTH           = DOT_WIDTH + 2;
   localparam int FIVE_WIDTH          = DOT_WIDTH + 3;
   localparam int RATIO_WIDTH         = 16;
   localparam int FRAC_BITS           = 8;
   localparam int SYMBOL_WIDTH        = 3;
   localparam int CSR_DATA_WIDTH      = 32;
   localparam int CSR_ADDR_WIDTH      = 3;
   localparam int CSR_INDEX_WIDTH     = 1;

   localparam logic [DOT_WIDTH-1:0]  DOT_RESET       = 16'd60;
   localparam logic [NOM_WIDTH-1:0]  THREE_DOT_RESET = 18'd180;
   localparam logic [FIVE_WIDTH-1:0] FIVE_DOT_RESET  = 19'd300;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOT_TICKS = 1'b0;

   localparam logic [SYMBOL_WIDTH-1:0] SYM_DOT          = 3'd0;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_DASH         = 3'd1;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_DOT_SPACE    = 3'd2;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_LETTER_SPACE = 3'd3;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_WORD_SPACE   = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

endpackage : mtc_pkg

`default_nettype wire

@@ hw/rtl/mtc_serial_divider.sv @@
// Bit-serial restoring divider that forms floor(d * 256 / nominal), saturated
// to 16 bits. One quotient bit per cycle. Depends on mtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtc_serial_divider #(
   parameter int COUNT_WIDTH = mtc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [COUNT_WIDTH-1:0]            dividend,
   input  logic [mtc_pkg::NOM_WIDTH-1:0]     divisor,
   output logic                              done,
   output logic [mtc_pkg::RATIO_WIDTH-1:0]   ratio
);
   import mtc_pkg::*;

   localparam int NUM_W = COUNT_WIDTH + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [NUM_W-1:0]       num_ff, num_in;
   logic [NOM_WIDTH-1:0]   div_ff, div_in;
   logic [NOM_WIDTH-1:0]   rem_ff, rem_in;
   logic [RATIO_WIDTH-1:0] quo_ff, quo_in;
   logic                   ovf_ff, ovf_in;

   logic [NOM_WIDTH:0]     trial;
   logic [NOM_WIDTH:0]     diff;
   logic                   fits;

   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = (trial >= {1'b0, div_ff});

      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      num_in   = num_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      ovf_in   = ovf_ff;

      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         num_in   = {dividend, {FRAC_BITS{1'b0}}};
         div_in   = divisor;
         rem_in   = '0;
         quo_in   = '0;
         ovf_in   = 1'b0;
      end else if (busy_ff) begin
         num_in   = {num_ff[NUM_W-2:0], 1'b0};
         rem_in   = fits ? diff[NOM_WIDTH-1:0] : trial[NOM_WIDTH-1:0];
         quo_in   = {quo_ff[RATIO_WIDTH-2:0], fits};
         ovf_in   = ovf_ff | quo_ff[RATIO_WIDTH-1];
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign done  = done_ff;
   assign ratio = ovf_ff ? {RATIO_WIDTH{1'b1}} : quo_ff;

endmodule : mtc_serial_divider

`default_nettype wire

@@ hw/rtl/morse_timing_classifier_unit.sv @@
// Top level of the Morse timing classifier: tick counter, symbol classifier,
// configuration registers and result register. Depends on mtc_pkg and
// mtc_serial_divider.
//
//   Channel   Ports          Direction  Carries
//   request   req_*          in         one key sample per millisecond tick
//   response  rsp_*          out        symbol and Q8.8 length ratio
//   csr       csr_p*         in/out     APB-style access to dot_ticks
//
// A tick without a level change, or the first change, does not use the divider.
// A change that ends a timed run holds req_ready low until the bit-serial
// divider forming the ratio is done and the result is written.
// Reset is synchronous and active high; dot_ticks returns to 60.
// A result waits in the output register; new ticks are still taken then, and
// only a finished division stalls until that register frees.
`timescale 1ns / 1ps
`default_nettype none

module morse_timing_classifier_unit #(
   parameter int COUNT_WIDTH = mtc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_key_on,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mtc_pkg::SYMBOL_WIDTH-1:0]     rsp_symbol,
   output logic [mtc_pkg::RATIO_WIDTH-1:0]      rsp_length_ratio,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mtc_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [mtc_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [mtc_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import mtc_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > FIVE_WIDTH) ? COUNT_WIDTH : FIVE_WIDTH;

   state_type               state_ff, state_in;

   logic [DOT_WIDTH-1:0]    dot_ff, dot_in;
   logic [NOM_WIDTH-1:0]    three_ff, three_in;
   logic [FIVE_WIDTH-1:0]   five_ff, five_in;

   logic                    key_level_ff, key_level_in;
   logic                    edge_seen_ff, edge_seen_in;
   logic [COUNT_WIDTH-1:0]  run_ff, run_in;

   logic [SYMBOL_WIDTH-1:0] sym_pend_ff, sym_pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_WIDTH-1:0] rsp_symbol_ff, rsp_symbol_in;
   logic [RATIO_WIDTH-1:0]  rsp_ratio_ff, rsp_ratio_in;

   logic                    csr_write;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic                    req_fire;
   logic [COUNT_WIDTH-1:0]  run_inc;
   logic [CMP_W-1:0]        d_ext;
   logic [CMP_W-1:0]        two_ext;
   logic [CMP_W-1:0]        five_ext;
   logic [SYMBOL_WIDTH-1:0] sym;
   logic [NOM_WIDTH-1:0]    nominal;
   logic                    div_start;
   logic                    div_done;
   logic [RATIO_WIDTH-1:0]  div_ratio;
   logic                    out_free;

   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_index == CSR_DOT_TICKS)
                       ? {{(CSR_DATA_WIDTH-DOT_WIDTH){1'b0}}, dot_ff} : '0;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      run_inc  = (run_ff == {COUNT_WIDTH{1'b1}}) ? run_ff : run_ff + 1'b1;
      d_ext    = CMP_W'(run_inc);
      two_ext  = CMP_W'({dot_ff, 1'b0});
      five_ext = CMP_W'(five_ff);

      if (!req_key_on) begin
         if (d_ext > two_ext) begin
            sym     = SYM_DASH;
            nominal = three_ff;
         end else begin
            sym     = SYM_DOT;
            nominal = NOM_WIDTH'(dot_ff);
         end
      end else begin
         if (d_ext < two_ext) begin
            sym     = SYM_DOT_SPACE;
            nominal = NOM_WIDTH'(dot_ff);
         end else if (d_ext < five_ext) begin
            sym     = SYM_LETTER_SPACE;
            nominal = three_ff;
         end else begin
            sym     = SYM_WORD_SPACE;
            nominal = three_ff;
         end
      end
   end

   always_comb begin
      dot_in   = dot_ff;
      three_in = three_ff;
      five_in  = five_ff;
      if (csr_write && csr_index == CSR_DOT_TICKS) begin
         dot_in   = csr_pwdata[DOT_WIDTH-1:0];
         three_in = NOM_WIDTH'({csr_pwdata[DOT_WIDTH-1:0], 1'b0})
                    + NOM_WIDTH'(csr_pwdata[DOT_WIDTH-1:0]);
         five_in  = FIVE_WIDTH'({csr_pwdata[DOT_WIDTH-1:0], 2'b00})
                    + FIVE_WIDTH'(csr_pwdata[DOT_WIDTH-1:0]);
      end
   end

   always_comb begin
      state_in      = state_ff;
      key_level_in  = key_level_ff;
      edge_seen_in  = edge_seen_ff;
      run_in        = run_ff;
      sym_pend_in   = sym_pend_ff;
      div_start     = 1'b0;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_ratio_in  = rsp_ratio_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_key_on != key_level_ff) begin
                  run_in       = '0;
                  key_level_in = req_key_on;
                  edge_seen_in = 1'b1;
                  if (edge_seen_ff) begin
                     sym_pend_in = sym;
                     div_start   = 1'b1;
                     state_in    = ST_DIVIDE;
                  end
               end else begin
                  run_in = run_inc;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_symbol_in = sym_pend_ff;
                  rsp_ratio_in  = div_ratio;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = sym_pend_ff;
               rsp_ratio_in  = div_ratio;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dot_ff       <= DOT_RESET;
         three_ff     <= THREE_DOT_RESET;
         five_ff      <= FIVE_DOT_RESET;
         key_level_ff <= 1'b0;
         edge_seen_ff <= 1'b0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dot_ff       <= dot_in;
         three_ff     <= three_in;
         five_ff      <= five_in;
         key_level_ff <= key_level_in;
         edge_seen_ff <= edge_seen_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_pend_ff   <= sym_pend_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_ratio_ff  <= rsp_ratio_in;
   end

   mtc_serial_divider #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (run_inc),
      .divisor  (nominal),
      .done     (div_done),
      .ratio    (div_ratio)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol       = rsp_symbol_ff;
   assign rsp_length_ratio = rsp_ratio_ff;

endmodule : morse_timing_classifier_unit

`default_nettype wire
